@@ design/ventilator_command_merge_macros.svh @@
// Assertion macros for ventilator_command_merge.sv, which checks its own logic.
`ifndef VENTILATOR_COMMAND_MERGE_MACROS_SVH
`define VENTILATOR_COMMAND_MERGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/vcm_pkg.sv @@
`timescale 1ns / 1ps

package vcm_pkg;

   localparam logic signed [7:0] KIV_MIN_OUTDOOR = 8'sd5;

   localparam int FF_KIV        = 0;
   localparam int FF_SOUND      = 1;
   localparam int FF_LED        = 2;
   localparam int FF_GATE       = 3;
   localparam int FF_MIXED      = 4;
   localparam int FF_ANTIFREEZE = 5;
   localparam int FF_AUTO_OK    = 6;

   localparam int PM_FAN    = 0;
   localparam int PM_POWER  = 1;
   localparam int PM_HEATER = 2;
   localparam int PM_TARGET = 3;
   localparam int PM_SOUND  = 4;
   localparam int PM_LED    = 5;
   localparam int PM_GATE   = 6;
   localparam int PM_AUTO   = 7;

   localparam int WARN_FAN        = 0;
   localparam int WARN_TEMP       = 1;
   localparam int WARN_ANTIFREEZE = 2;
   localparam int WARN_KIV        = 3;
   localparam int WARN_AUTO       = 4;

   localparam logic FUNC_COMMAND = 1'b0;
   localparam logic FUNC_REPORT  = 1'b1;

   localparam logic [1:0] CSR_FEATURE_FLAGS = 2'd0;
   localparam logic [1:0] CSR_MAX_FAN_LEVEL = 2'd1;
   localparam logic [1:0] CSR_MIN_SETPOINT  = 2'd2;
   localparam logic [1:0] CSR_MAX_SETPOINT  = 2'd3;

   localparam logic [1:0] GATE_OUTDOOR = 2'd0;
   localparam logic [1:0] GATE_INDOOR  = 2'd1;
   localparam logic [1:0] GATE_MIXED   = 2'd2;
   localparam logic [1:0] GATE_OTHER   = 2'd3;

   localparam logic [6:0]        RESET_FEATURE_FLAGS = 7'd0;
   localparam logic [3:0]        RESET_MAX_FAN_LEVEL = 4'd6;
   localparam logic signed [7:0] RESET_MIN_SETPOINT  = 8'sd0;
   localparam logic signed [7:0] RESET_MAX_SETPOINT  = 8'sd30;

   typedef struct packed {
      logic              func;
      logic [7:0]        present_mask;
      logic [3:0]        fan_level;
      logic              power_on;
      logic              heater_on;
      logic signed [7:0] setpoint;
      logic              sound_on;
      logic              led_on;
      logic [1:0]        gate_code;
      logic              auto_on;
      logic signed [7:0] outside_temp;
   } req_type;

   typedef struct packed {
      logic              power;
      logic              heater;
      logic [3:0]        fan_level;
      logic signed [7:0] setpoint;
      logic              sound;
      logic              led;
      logic [1:0]        gate;
      logic              auto_on;
      logic signed [7:0] outside_temp;
   } state_type;

   typedef struct packed {
      logic [6:0]        feature_flags;
      logic [3:0]        max_fan_level;
      logic signed [7:0] min_setpoint;
      logic signed [7:0] max_setpoint;
   } cfg_type;

   typedef struct packed {
      logic       we;
      logic [1:0] index;
      logic [7:0] wdata;
   } csr_type;

   typedef struct packed {
      logic              new_power;
      logic              new_heater;
      logic [3:0]        new_fan_level;
      logic signed [7:0] new_setpoint;
      logic              new_sound;
      logic              new_led;
      logic [1:0]        new_gate;
      logic              new_auto;
      logic              auto_source;
      logic [4:0]        warn_flags;
   } rsp_type;

endpackage

@@ design/ventilator_command_merge.sv @@
`timescale 1ns / 1ps
// Channel  Ports                  Direction  Payload
// req      req_tvalid/tready      in         tdata 40 bits, tuser = func
// rsp      rsp_tvalid/tready      out        tdata 24 bits, tuser = auto_source
// csr      csr_we/index/wdata     in         four registers, write only
//
// An item waits in the input register and then sits in the result register.
// The block takes one item per cycle while the result register is not stalled.
// A stalled result holds the result register, and the input register then holds too.
// Reset clears the stored device state and loads the register defaults.
// A report item updates the stored state as it moves from the input register onward.

`include "ventilator_command_merge_macros.svh"

module ventilator_command_merge (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // present_mask, fan_level, power_on, heater_on, setpoint, sound_on, led_on,
   // gate_code, auto_on, outside_temp, zero pad
   input  logic [39:0] req_tdata,
   // func
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_power, new_heater, new_fan_level, new_setpoint, new_sound, new_led,
   // new_gate, new_auto, warn_flags
   output logic [23:0] rsp_tdata,
   // auto_source
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   vcm_pkg::req_type   item_ff, item_in;
   vcm_pkg::rsp_type   rsp_ff;
   vcm_pkg::rsp_type   rsp_in;
   vcm_pkg::state_type state;
   vcm_pkg::cfg_type   cfg;
   vcm_pkg::csr_type   csr;
   logic               in_valid_ff;
   logic               out_valid_ff;
   logic               advance;
   logic               take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   always_comb begin
      item_in.func         = req_tuser[0];
      item_in.present_mask = req_tdata[7:0];
      item_in.fan_level    = req_tdata[11:8];
      item_in.power_on     = req_tdata[12];
      item_in.heater_on    = req_tdata[13];
      item_in.setpoint     = req_tdata[21:14];
      item_in.sound_on     = req_tdata[22];
      item_in.led_on       = req_tdata[23];
      item_in.gate_code    = req_tdata[25:24];
      item_in.auto_on      = req_tdata[26];
      item_in.outside_temp = req_tdata[34:27];
   end

   vcm_state u_state (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .load  (advance),
      .item  (item_ff),
      .state (state),
      .cfg   (cfg)
   );

   vcm_merge u_merge (
      .item  (item_ff),
      .state (state),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) item_ff <= item_in;
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rsp_ff.warn_flags, rsp_ff.new_auto, rsp_ff.new_gate, rsp_ff.new_led,
                        rsp_ff.new_sound, rsp_ff.new_setpoint, rsp_ff.new_fan_level,
                        rsp_ff.new_heater, rsp_ff.new_power};
   assign rsp_tuser  = rsp_ff.auto_source;

   `VCM_ASSERT_NOW(a_ready_when_out_empty, !out_valid_ff, req_tready,
      "Input not ready although the result register is empty.")
   `VCM_ASSERT_NEXT(a_blocked_item_held, in_valid_ff && !advance, in_valid_ff,
      "Item lost from the input register while blocked.")
   `VCM_ASSERT_NEXT(a_advance_fills_out, advance, rsp_tvalid,
      "Item advanced but no result became valid.")
   `VCM_ASSERT_NEXT(a_report_no_warn, advance && item_ff.func == vcm_pkg::FUNC_REPORT,
      rsp_tdata[23:19] == 5'd0 && state.auto_on == rsp_tuser[0],
      "Report result carries warnings or does not match the loaded state.")

endmodule

@@ design/vcm_state.sv @@
`timescale 1ns / 1ps

module vcm_state (
   input  logic               clock,
   input  logic               reset,
   input  vcm_pkg::csr_type   csr,
   input  logic               load,
   input  vcm_pkg::req_type   item,
   output vcm_pkg::state_type state,
   output vcm_pkg::cfg_type   cfg
);

   vcm_pkg::state_type state_ff, state_in;
   vcm_pkg::cfg_type   cfg_ff, cfg_in;

   always_comb begin
      state_in = state_ff;
      if (load && item.func == vcm_pkg::FUNC_REPORT) begin
         state_in.power        = item.power_on;
         state_in.heater       = item.heater_on;
         state_in.fan_level    = item.fan_level;
         state_in.setpoint     = item.setpoint;
         state_in.sound        = item.sound_on;
         state_in.led          = item.led_on;
         state_in.gate         = item.gate_code;
         state_in.auto_on      = item.auto_on;
         state_in.outside_temp = item.outside_temp;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.we) begin
         unique case (csr.index)
            vcm_pkg::CSR_FEATURE_FLAGS: cfg_in.feature_flags = csr.wdata[6:0];
            vcm_pkg::CSR_MAX_FAN_LEVEL: cfg_in.max_fan_level = csr.wdata[3:0];
            vcm_pkg::CSR_MIN_SETPOINT:  cfg_in.min_setpoint  = csr.wdata;
            vcm_pkg::CSR_MAX_SETPOINT:  cfg_in.max_setpoint  = csr.wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cfg_ff.feature_flags <= vcm_pkg::RESET_FEATURE_FLAGS;
         cfg_ff.max_fan_level <= vcm_pkg::RESET_MAX_FAN_LEVEL;
         cfg_ff.min_setpoint  <= vcm_pkg::RESET_MIN_SETPOINT;
         cfg_ff.max_setpoint  <= vcm_pkg::RESET_MAX_SETPOINT;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
   end

   assign state = state_ff;
   assign cfg   = cfg_ff;

endmodule

@@ design/vcm_merge.sv @@
`timescale 1ns / 1ps

module vcm_merge (
   input  vcm_pkg::req_type   item,
   input  vcm_pkg::state_type state,
   input  vcm_pkg::cfg_type   cfg,
   output vcm_pkg::rsp_type   rsp
);

   always_comb begin
      logic       has_pwr;
      logic       has_gate;
      logic       auto_req;
      logic       pwr;
      logic       p;
      logic [1:0] gate;
      logic [1:0] g;
      logic       n_power;
      logic       n_heater;
      logic [3:0] n_fan;
      logic [7:0] n_tgt;
      logic       n_sound;
      logic       n_led;
      logic [1:0] n_gate;
      logic       n_auto;
      logic       src;
      logic [4:0] warn;
      logic [6:0] ff;

      ff       = cfg.feature_flags;
      has_pwr  = item.present_mask[vcm_pkg::PM_POWER];
      has_gate = item.present_mask[vcm_pkg::PM_GATE];
      auto_req = item.present_mask[vcm_pkg::PM_AUTO] && item.auto_on;
      pwr      = item.power_on;
      gate     = item.gate_code;
      g        = gate;
      p        = 1'b0;
      n_power  = state.power;
      n_heater = state.heater;
      n_fan    = state.fan_level;
      n_tgt    = state.setpoint;
      n_sound  = state.sound;
      n_led    = state.led;
      n_gate   = state.gate;
      n_auto   = state.auto_on;
      warn     = '0;

      if (item.func == vcm_pkg::FUNC_REPORT) begin
         n_power  = item.power_on;
         n_heater = item.heater_on;
         n_fan    = item.fan_level;
         n_tgt    = item.setpoint;
         n_sound  = item.sound_on;
         n_led    = item.led_on;
         n_gate   = item.gate_code;
         n_auto   = item.auto_on;
         src      = item.auto_on;
      end else begin
         if (item.present_mask[vcm_pkg::PM_AUTO] && state.auto_on != item.auto_on) begin
            if (item.auto_on && !ff[vcm_pkg::FF_AUTO_OK]) begin
               n_auto = 1'b0;
               warn[vcm_pkg::WARN_AUTO] = 1'b1;
            end else begin
               n_auto = item.auto_on;
            end
            if (n_auto) begin
               has_gate = 1'b1;
               gate     = vcm_pkg::GATE_OUTDOOR;
            end
         end
         src = n_auto;

         if (item.present_mask[vcm_pkg::PM_FAN]) begin
            priority if (item.fan_level == 4'd0 && !ff[vcm_pkg::FF_KIV]) begin
               p = has_pwr ? pwr : state.power;
               if (p) begin
                  has_pwr = 1'b1;
                  pwr     = 1'b0;
               end
            end else if (item.fan_level > cfg.max_fan_level) begin
               warn[vcm_pkg::WARN_FAN] = 1'b1;
            end else begin
               if (state.fan_level != item.fan_level) begin
                  n_fan = item.fan_level;
                  if (!auto_req) n_auto = 1'b0;
               end
            end
         end

         if (has_pwr && state.power != pwr) begin
            n_power = pwr;
            if (!auto_req && !pwr) n_auto = 1'b0;
         end

         if (item.present_mask[vcm_pkg::PM_HEATER]) n_heater = item.heater_on;

         if (item.present_mask[vcm_pkg::PM_TARGET] && state.setpoint != item.setpoint)
         begin
            if (item.setpoint < cfg.min_setpoint ||
                item.setpoint > cfg.max_setpoint) begin
               warn[vcm_pkg::WARN_TEMP] = 1'b1;
            end else begin
               n_tgt = item.setpoint;
            end
         end

         if (ff[vcm_pkg::FF_SOUND] && item.present_mask[vcm_pkg::PM_SOUND])
            n_sound = item.sound_on;
         if (ff[vcm_pkg::FF_LED] && item.present_mask[vcm_pkg::PM_LED])
            n_led = item.led_on;

         if (ff[vcm_pkg::FF_GATE] && has_gate) begin
            g = gate;
            priority if (gate == vcm_pkg::GATE_INDOOR) begin
               n_heater = 1'b0;
            end else if (gate == vcm_pkg::GATE_MIXED) begin
               if (!ff[vcm_pkg::FF_MIXED]) g = state.gate;
            end else begin
               if (gate != vcm_pkg::GATE_OUTDOOR) g = state.gate;
            end
            if (state.gate != g) begin
               n_gate = g;
               if (!auto_req && g != vcm_pkg::GATE_OUTDOOR) n_auto = 1'b0;
            end
         end

         if (ff[vcm_pkg::FF_ANTIFREEZE] && n_power && !n_heater && state.outside_temp[7])
         begin
            n_heater = 1'b1;
            warn[vcm_pkg::WARN_ANTIFREEZE] = 1'b1;
         end

         if (ff[vcm_pkg::FF_KIV] && n_power && n_fan == 4'd0) begin
            if (state.outside_temp < vcm_pkg::KIV_MIN_OUTDOOR || n_heater) begin
               n_power = 1'b0;
               warn[vcm_pkg::WARN_KIV] = 1'b1;
            end
         end
      end

      rsp.new_power     = n_power;
      rsp.new_heater    = n_heater;
      rsp.new_fan_level = n_fan;
      rsp.new_setpoint  = n_tgt;
      rsp.new_sound     = n_sound;
      rsp.new_led       = n_led;
      rsp.new_gate      = n_gate;
      rsp.new_auto      = n_auto;
      rsp.auto_source   = src;
      rsp.warn_flags    = warn;
   end

endmodule

@@ tb/tb_ventilator_command_merge.sv @@
`timescale 1ns / 1ps

module tb_ventilator_command_merge;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 240;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   ventilator_command_merge dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   vcm_pkg::state_type device = '0;
   vcm_pkg::cfg_type   settings = '{vcm_pkg::RESET_FEATURE_FLAGS, vcm_pkg::RESET_MAX_FAN_LEVEL,
                                    vcm_pkg::RESET_MIN_SETPOINT, vcm_pkg::RESET_MAX_SETPOINT};
   vcm_pkg::req_type   pending[$];
   vcm_pkg::rsp_type   merged_states[$];
   vcm_pkg::req_type   on_wire;
   vcm_pkg::rsp_type   oldest;
   logic               req_fired = 1'b0;
   int                 burst_left = 0;
   int                 gap_left = 0;
   int                 stall_left = 0;
   ready_mode_type     ready_mode = READY_ALWAYS;
   int                 mismatches = 0;
   int                 cycles = 0;

   function automatic vcm_pkg::rsp_type merge_item(vcm_pkg::req_type r);
      vcm_pkg::rsp_type o;
      logic       has_pwr;
      logic       has_gate;
      logic       auto_req;
      logic       pwr;
      logic [1:0] gate;
      logic [1:0] g;
      o.new_power     = device.power;
      o.new_heater    = device.heater;
      o.new_fan_level = device.fan_level;
      o.new_setpoint  = device.setpoint;
      o.new_sound     = device.sound;
      o.new_led       = device.led;
      o.new_gate      = device.gate;
      o.new_auto      = device.auto_on;
      o.auto_source   = device.auto_on;
      o.warn_flags    = '0;
      if (r.func == vcm_pkg::FUNC_REPORT) begin
         device.power        = r.power_on;
         device.heater       = r.heater_on;
         device.fan_level    = r.fan_level;
         device.setpoint     = r.setpoint;
         device.sound        = r.sound_on;
         device.led          = r.led_on;
         device.gate         = r.gate_code;
         device.auto_on      = r.auto_on;
         device.outside_temp = r.outside_temp;
         o.new_power     = r.power_on;
         o.new_heater    = r.heater_on;
         o.new_fan_level = r.fan_level;
         o.new_setpoint  = r.setpoint;
         o.new_sound     = r.sound_on;
         o.new_led       = r.led_on;
         o.new_gate      = r.gate_code;
         o.new_auto      = r.auto_on;
         o.auto_source   = r.auto_on;
      end else begin
         has_pwr  = r.present_mask[vcm_pkg::PM_POWER];
         has_gate = r.present_mask[vcm_pkg::PM_GATE];
         auto_req = r.present_mask[vcm_pkg::PM_AUTO] && r.auto_on;
         pwr      = r.power_on;
         gate     = r.gate_code;
         if (r.present_mask[vcm_pkg::PM_AUTO] && device.auto_on != r.auto_on) begin
            if (r.auto_on && !settings.feature_flags[vcm_pkg::FF_AUTO_OK]) begin
               o.new_auto = 1'b0;
               o.warn_flags[vcm_pkg::WARN_AUTO] = 1'b1;
            end else begin
               o.new_auto = r.auto_on;
            end
            if (o.new_auto) begin
               has_gate = 1'b1;
               gate = vcm_pkg::GATE_OUTDOOR;
            end
         end
         o.auto_source = o.new_auto;
         if (r.present_mask[vcm_pkg::PM_FAN]) begin
            if (r.fan_level == 4'd0 && !settings.feature_flags[vcm_pkg::FF_KIV]) begin
               if (has_pwr ? pwr : device.power) begin
                  has_pwr = 1'b1;
                  pwr = 1'b0;
               end
            end else if (r.fan_level > settings.max_fan_level) begin
               o.warn_flags[vcm_pkg::WARN_FAN] = 1'b1;
            end else if (device.fan_level != r.fan_level) begin
               o.new_fan_level = r.fan_level;
               if (!auto_req) o.new_auto = 1'b0;
            end
         end
         if (has_pwr && device.power != pwr) begin
            o.new_power = pwr;
            if (!auto_req && !pwr) o.new_auto = 1'b0;
         end
         if (r.present_mask[vcm_pkg::PM_HEATER] && device.heater != r.heater_on)
            o.new_heater = r.heater_on;
         if (r.present_mask[vcm_pkg::PM_TARGET] && device.setpoint != r.setpoint) begin
            if ($signed(r.setpoint) < $signed(settings.min_setpoint) ||
                $signed(r.setpoint) > $signed(settings.max_setpoint))
               o.warn_flags[vcm_pkg::WARN_TEMP] = 1'b1;
            else
               o.new_setpoint = r.setpoint;
         end
         if (settings.feature_flags[vcm_pkg::FF_SOUND] && r.present_mask[vcm_pkg::PM_SOUND])
            o.new_sound = r.sound_on;
         if (settings.feature_flags[vcm_pkg::FF_LED] && r.present_mask[vcm_pkg::PM_LED])
            o.new_led = r.led_on;
         if (settings.feature_flags[vcm_pkg::FF_GATE] && has_gate) begin
            g = gate;
            if (g == vcm_pkg::GATE_INDOOR) begin
               o.new_heater = 1'b0;
            end else if (g == vcm_pkg::GATE_MIXED) begin
               if (!settings.feature_flags[vcm_pkg::FF_MIXED]) g = device.gate;
            end else if (g != vcm_pkg::GATE_OUTDOOR) begin
               g = device.gate;
            end
            if (device.gate != g) begin
               o.new_gate = g;
               if (!auto_req && g != vcm_pkg::GATE_OUTDOOR) o.new_auto = 1'b0;
            end
         end
         if (settings.feature_flags[vcm_pkg::FF_ANTIFREEZE] && o.new_power &&
             !o.new_heater && $signed(device.outside_temp) < 0) begin
            o.new_heater = 1'b1;
            o.warn_flags[vcm_pkg::WARN_ANTIFREEZE] = 1'b1;
         end
         if (settings.feature_flags[vcm_pkg::FF_KIV] && o.new_power &&
             o.new_fan_level == 4'd0) begin
            if ($signed(device.outside_temp) < vcm_pkg::KIV_MIN_OUTDOOR || o.new_heater) begin
               o.new_power = 1'b0;
               o.warn_flags[vcm_pkg::WARN_KIV] = 1'b1;
            end
         end
      end
      return o;
   endfunction

   function automatic vcm_pkg::req_type compose(logic func, logic [7:0] mask,
                                                logic [3:0] fan, logic pwr, logic heat,
                                                logic [7:0] tgt, logic snd, logic led,
                                                logic [1:0] gate, logic aut,
                                                logic [7:0] outd);
      vcm_pkg::req_type r;
      r.func         = func;
      r.present_mask = mask;
      r.fan_level    = fan;
      r.power_on     = pwr;
      r.heater_on    = heat;
      r.setpoint     = tgt;
      r.sound_on     = snd;
      r.led_on       = led;
      r.gate_code    = gate;
      r.auto_on      = aut;
      r.outside_temp = outd;
      return r;
   endfunction

   function automatic vcm_pkg::req_type random_item();
      vcm_pkg::req_type r;
      r.func = ($urandom_range(0, 3) == 0) ? vcm_pkg::FUNC_REPORT : vcm_pkg::FUNC_COMMAND;
      if ($urandom_range(0, 3) == 0)
         r.present_mask = 8'h01 << $urandom_range(0, 7);
      else
         r.present_mask = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0: r.fan_level = 4'd0;
         1: r.fan_level = settings.max_fan_level;
         2: r.fan_level = settings.max_fan_level + 4'd1;
         default: r.fan_level = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 5))
         0: r.setpoint = settings.min_setpoint;
         1: r.setpoint = settings.max_setpoint;
         2: r.setpoint = settings.min_setpoint - 8'sd1;
         3: r.setpoint = settings.max_setpoint + 8'sd1;
         default: r.setpoint = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
         0: r.outside_temp = 8'hFF;
         1: r.outside_temp = 8'd0;
         2: r.outside_temp = vcm_pkg::KIV_MIN_OUTDOOR - 8'sd1;
         3: r.outside_temp = vcm_pkg::KIV_MIN_OUTDOOR;
         default: r.outside_temp = 8'($urandom_range(0, 255));
      endcase
      r.power_on  = 1'($urandom_range(0, 1));
      r.heater_on = 1'($urandom_range(0, 1));
      r.sound_on  = 1'($urandom_range(0, 1));
      r.led_on    = 1'($urandom_range(0, 1));
      r.gate_code = 2'($urandom_range(0, 3));
      r.auto_on   = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic enqueue(vcm_pkg::req_type r);
      pending.insert(pending.size(), r);
   endtask

   task automatic note_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic write_reg(logic [1:0] index, logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   task automatic set_config(logic [6:0] flags, logic [3:0] fan_max, logic [7:0] lo,
                             logic [7:0] hi);
      write_reg(vcm_pkg::CSR_FEATURE_FLAGS, {1'($urandom_range(0, 1)), flags});
      write_reg(vcm_pkg::CSR_MAX_FAN_LEVEL, {4'($urandom_range(0, 15)), fan_max});
      write_reg(vcm_pkg::CSR_MIN_SETPOINT, lo);
      write_reg(vcm_pkg::CSR_MAX_SETPOINT, hi);
      @(negedge clock);
      csr_we <= 1'b0;
      settings = '{flags, fan_max, lo, hi};
   endtask

   task automatic settle();
      while (pending.size() != 0 || req_tvalid || merged_states.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic directed_items();
      enqueue(compose(vcm_pkg::FUNC_REPORT, 8'h00, 4'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0,
                      vcm_pkg::GATE_OUTDOOR, 1'b0, 8'd0));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'h00, 4'd9, 1'b1, 1'b1, 8'd77, 1'b1, 1'b1,
                      vcm_pkg::GATE_OTHER, 1'b1, 8'hFB));
      enqueue(compose(vcm_pkg::FUNC_REPORT, 8'hFF, 4'd15, 1'b1, 1'b1, 8'h7F, 1'b1, 1'b1,
                      vcm_pkg::GATE_OTHER, 1'b1, 8'h7F));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'hFF, 4'd0, 1'b0, 1'b0, 8'h80, 1'b0, 1'b0,
                      vcm_pkg::GATE_INDOOR, 1'b0, 8'h80));
      enqueue(compose(vcm_pkg::FUNC_REPORT, 8'h00, 4'd3, 1'b1, 1'b0, 8'd20, 1'b0, 1'b0,
                      vcm_pkg::GATE_OUTDOOR, 1'b0, 8'h80));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'h01 << vcm_pkg::PM_AUTO, 4'd0, 1'b0, 1'b0,
                      8'd0, 1'b0, 1'b0, vcm_pkg::GATE_INDOOR, 1'b1, 8'd0));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'h01 << vcm_pkg::PM_FAN, 4'd0, 1'b0, 1'b0,
                      8'd0, 1'b0, 1'b0, vcm_pkg::GATE_OUTDOOR, 1'b0, 8'd0));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'h01 << vcm_pkg::PM_FAN, 4'd15, 1'b0, 1'b0,
                      8'd0, 1'b0, 1'b0, vcm_pkg::GATE_OUTDOOR, 1'b0, 8'd0));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'h01 << vcm_pkg::PM_TARGET, 4'd0, 1'b0, 1'b0,
                      8'h7F, 1'b0, 1'b0, vcm_pkg::GATE_OUTDOOR, 1'b0, 8'd0));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'h01 << vcm_pkg::PM_GATE, 4'd0, 1'b0, 1'b0,
                      8'd0, 1'b0, 1'b0, vcm_pkg::GATE_MIXED, 1'b0, 8'd0));
      enqueue(compose(vcm_pkg::FUNC_REPORT, 8'h00, 4'd0, 1'b1, 1'b0, 8'd10, 1'b0, 1'b0,
                      vcm_pkg::GATE_INDOOR, 1'b1, vcm_pkg::KIV_MIN_OUTDOOR - 8'sd1));
      enqueue(compose(vcm_pkg::FUNC_COMMAND, 8'h01 << vcm_pkg::PM_FAN, 4'd0, 1'b1, 1'b0,
                      8'd0, 1'b0, 1'b0, vcm_pkg::GATE_OUTDOOR, 1'b0, 8'd0));
   endtask

   // The sender works in bursts of items, usually separated by idle gaps.
   always @(negedge clock) begin
      if (!req_tvalid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending.size() > 0) begin
            on_wire = pending.pop_front();
            req_tdata <= {5'b0, on_wire.outside_temp, on_wire.auto_on, on_wire.gate_code,
                          on_wire.led_on, on_wire.sound_on, on_wire.setpoint,
                          on_wire.heater_on, on_wire.power_on, on_wire.fan_level,
                          on_wire.present_mask};
            req_tuser <= on_wire.func;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 150);
      end else begin
         stall_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= (stall_left % 4 == 0);
         default:      rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      req_fired <= req_tvalid && req_tready;
      cycles++;
      if (!reset) begin
         if (req_tvalid && req_tready)
            merged_states.insert(merged_states.size(), merge_item(on_wire));
         if (rsp_tvalid && rsp_tready) begin
            if (merged_states.size() == 0) begin
               note_mismatch("result arrived with no item outstanding");
            end else begin
               oldest = merged_states.pop_front();
               check_field("new_power", 8'(rsp_tdata[0]), 8'(oldest.new_power));
               check_field("new_heater", 8'(rsp_tdata[1]), 8'(oldest.new_heater));
               check_field("new_fan_level", 8'(rsp_tdata[5:2]), 8'(oldest.new_fan_level));
               check_field("new_setpoint", rsp_tdata[13:6], oldest.new_setpoint);
               check_field("new_sound", 8'(rsp_tdata[14]), 8'(oldest.new_sound));
               check_field("new_led", 8'(rsp_tdata[15]), 8'(oldest.new_led));
               check_field("new_gate", 8'(rsp_tdata[17:16]), 8'(oldest.new_gate));
               check_field("new_auto", 8'(rsp_tdata[18]), 8'(oldest.new_auto));
               check_field("warn_flags", 8'(rsp_tdata[23:19]), 8'(oldest.warn_flags));
               check_field("auto_source", 8'(rsp_tuser[0]), 8'(oldest.auto_source));
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("ventilator_command_merge: mismatch");
         $finish;
      end
   end

   initial begin
      int lo;
      int hi;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_items();
      settle();
      set_config(7'h7F, 4'd15, 8'h80, 8'h7F);
      directed_items();
      settle();

      // Inverted temperature window with every feature off.
      set_config(7'h00, 4'd1, 8'h7F, 8'h80);
      repeat (RANDOM_PER_PHASE) enqueue(random_item());
      settle();
      set_config(7'h7F, 4'd6, 8'd0, 8'd30);
      repeat (RANDOM_PER_PHASE) enqueue(random_item());
      settle();

      repeat (6) begin
         lo = $urandom_range(0, 60) - 30;
         hi = lo + $urandom_range(0, 40);
         if ($urandom_range(0, 3) == 0)
            set_config(7'($urandom_range(0, 127)), 4'($urandom_range(1, 15)),
                       8'(hi), 8'(lo));
         else
            set_config(7'($urandom_range(0, 127)), 4'($urandom_range(1, 15)),
                       8'(lo), 8'(hi));
         repeat (RANDOM_PER_PHASE) enqueue(random_item());
         settle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("ventilator_command_merge: match");
      else
         $display("ventilator_command_merge: mismatch");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/vcm_pkg.sv
design/vcm_state.sv
design/vcm_merge.sv
design/ventilator_command_merge.sv
tb/tb_ventilator_command_merge.sv
